// ===== rtl/scc_pkg.sv =====
// shared types, register indexes and width helpers for the sphere capsule contact core
package scc_pkg;

   localparam int COORD_W = 32;
   localparam int AXIS_W = 18;
   localparam int LEN_W = 31;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_CENTER_Z = 3'd2,
      REG_AXIS_X = 3'd3,
      REG_AXIS_Y = 3'd4,
      REG_AXIS_Z = 3'd5,
      REG_HALF_HEIGHT = 3'd6,
      REG_RADIUS = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      PART_SIDE = 2'd0,
      PART_BOTTOM = 2'd1,
      PART_TOP = 2'd2
   } part_type;

   localparam logic [AXIS_W-1:0] AXIS_Z_RESET = 18'd65536;
   localparam logic [LEN_W-1:0] HALF_HEIGHT_RESET = 31'd65536;
   localparam logic [LEN_W-1:0] RADIUS_RESET = 31'd65536;

   // index 0 is x, 1 is y, 2 is z
   typedef struct packed {
      logic [2:0][COORD_W-1:0] center;
      logic [2:0][AXIS_W-1:0] axis;
      logic [LEN_W-1:0] half_height;
      logic [LEN_W-1:0] radius;
   } capsule_type;

   // width of the cap center and offset vectors
   function automatic int vec_width(input int frac);
      int side_w;
      int cap_w;
      int w;
      side_w = 2 * AXIS_W + COORD_W + 3 - 2 * frac;
      cap_w = AXIS_W + LEN_W + 1 - frac;
      w = COORD_W;
      if (side_w > w) w = side_w;
      if (cap_w > w) w = cap_w;
      return w + 2;
   endfunction

endpackage

// ===== rtl/scc_geom.sv =====
// projection pipeline: axis projection, feature choice, feature center and offset
module scc_geom #(
   parameter int FRAC_BITS = 16,
   parameter int VEC_W = 39
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic signed [scc_pkg::COORD_W-1:0] sphere_center [3],
   input  logic [scc_pkg::LEN_W-1:0] sphere_radius,
   input  scc_pkg::capsule_type capsule,
   output logic out_valid,
   output logic [scc_pkg::LEN_W-1:0] out_radius,
   output scc_pkg::part_type out_part,
   output logic signed [VEC_W-1:0] out_base [3],
   output logic signed [VEC_W-1:0] out_offset [3]
);

   localparam int CW = scc_pkg::COORD_W;
   localparam int AW = scc_pkg::AXIS_W;
   localparam int LW = scc_pkg::LEN_W;
   localparam int DW = CW + 1;
   localparam int PW = AW + DW;
   localparam int SW = PW + 2;
   localparam int HW = SW - FRAC_BITS;
   localparam int SPW = AW + HW;
   localparam int CPW = AW + LW + 1;
   localparam int MW = (HW > LW ? HW : LW) + 1;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [LW-1:0] sr1_ff, sr2_ff, sr3_ff, sr4_ff, sr5_ff;
   logic signed [CW-1:0] sc1_ff [3];
   logic signed [CW-1:0] sc2_ff [3];
   logic signed [CW-1:0] sc3_ff [3];
   logic signed [CW-1:0] sc4_ff [3];
   logic signed [DW-1:0] d1_in [3];
   logic signed [DW-1:0] d1_ff [3];
   logic signed [PW-1:0] p2_in [3];
   logic signed [PW-1:0] p2_ff [3];
   logic signed [SW-1:0] sum3;
   logic signed [HW-1:0] h3_in;
   logic signed [HW-1:0] h3_ff;
   logic signed [SPW-1:0] sp4_in [3];
   logic signed [SPW-1:0] sp4_ff [3];
   logic signed [CPW-1:0] capp_in [3];
   logic signed [CPW-1:0] capp_ff [3];
   logic signed [MW-1:0] hx4;
   logic [MW-1:0] habs4;
   scc_pkg::part_type part4_in, part4_ff, part5_ff;
   logic signed [VEC_W-1:0] base5_in [3];
   logic signed [VEC_W-1:0] base5_ff [3];
   logic signed [VEC_W-1:0] off5_in [3];
   logic signed [VEC_W-1:0] off5_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = DW'(sphere_center[i]) - DW'($signed(capsule.center[i]));
         p2_in[i] = $signed(capsule.axis[i]) * d1_ff[i];
         sp4_in[i] = $signed(capsule.axis[i]) * h3_ff;
         capp_in[i] = $signed(capsule.axis[i]) * $signed({1'b0, capsule.half_height});
      end
      sum3 = SW'(p2_ff[0]) + SW'(p2_ff[1]) + SW'(p2_ff[2]);
      h3_in = sum3[SW-1:FRAC_BITS];
   end

   always_comb begin
      hx4 = MW'(h3_ff);
      habs4 = hx4[MW-1] ? MW'(-hx4) : MW'(hx4);
      if (habs4 < MW'(capsule.half_height)) begin
         part4_in = scc_pkg::PART_SIDE;
      end else if (hx4[MW-1]) begin
         part4_in = scc_pkg::PART_BOTTOM;
      end else begin
         part4_in = scc_pkg::PART_TOP;
      end
   end

   always_comb begin
      logic signed [VEC_W-1:0] ccv;
      logic signed [VEC_W-1:0] a_side;
      logic signed [VEC_W-1:0] a_cap;
      for (int i = 0; i < 3; i++) begin
         ccv = VEC_W'($signed(capsule.center[i]));
         a_side = VEC_W'($signed(sp4_ff[i][SPW-1:FRAC_BITS]));
         a_cap = VEC_W'($signed(capp_ff[i][CPW-1:FRAC_BITS]));
         case (part4_ff)
            scc_pkg::PART_SIDE: base5_in[i] = ccv + a_side;
            scc_pkg::PART_TOP: base5_in[i] = ccv + a_cap;
            scc_pkg::PART_BOTTOM: base5_in[i] = ccv - a_cap;
            default: base5_in[i] = ccv;
         endcase
         off5_in[i] = VEC_W'(sc4_ff[i]) - base5_in[i];
      end
   end

   // cap offsets depend on configuration only
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) capp_ff[i] <= capp_in[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sr1_ff <= sphere_radius;
         sr2_ff <= sr1_ff;
         sr3_ff <= sr2_ff;
         sr4_ff <= sr3_ff;
         sr5_ff <= sr4_ff;
         h3_ff <= h3_in;
         part4_ff <= part4_in;
         part5_ff <= part4_ff;
         for (int i = 0; i < 3; i++) begin
            sc1_ff[i] <= sphere_center[i];
            sc2_ff[i] <= sc1_ff[i];
            sc3_ff[i] <= sc2_ff[i];
            sc4_ff[i] <= sc3_ff[i];
            d1_ff[i] <= d1_in[i];
            p2_ff[i] <= p2_in[i];
            sp4_ff[i] <= sp4_in[i];
            base5_ff[i] <= base5_in[i];
            off5_ff[i] <= off5_in[i];
         end
      end
   end

   assign out_valid = v5_ff;
   assign out_radius = sr5_ff;
   assign out_part = part5_ff;
   assign out_base = base5_ff;
   assign out_offset = off5_ff;

endmodule

// ===== rtl/scc_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module scc_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [63:0] in_radicand,
   input  logic [SIDE_W-1:0] in_side,
   output logic out_valid,
   output logic [31:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STAGES = 32;

   logic valid_ff [STAGES];
   logic [63:0] rad_ff [STAGES];
   logic [33:0] rem_ff [STAGES];
   logic [31:0] root_ff [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic prev_valid;
      logic [63:0] prev_rad;
      logic [33:0] prev_rem;
      logic [31:0] prev_root;
      logic [SIDE_W-1:0] prev_side;
      logic [35:0] acc;
      logic [35:0] trial;
      logic [63:0] rad_in;
      logic [33:0] rem_in;
      logic [31:0] root_in;

      if (k == 0) begin : g_head
         always_comb begin
            prev_valid = in_valid;
            prev_rad = in_radicand;
            prev_rem = '0;
            prev_root = '0;
            prev_side = in_side;
         end
      end else begin : g_tail
         always_comb begin
            prev_valid = valid_ff[k-1];
            prev_rad = rad_ff[k-1];
            prev_rem = rem_ff[k-1];
            prev_root = root_ff[k-1];
            prev_side = side_ff[k-1];
         end
      end

      always_comb begin
         acc = {prev_rem, prev_rad[63:62]};
         trial = {2'b00, prev_root, 2'b01};
         rad_in = {prev_rad[61:0], 2'b00};
         if (acc >= trial) begin
            rem_in = 34'(acc - trial);
            root_in = {prev_root[30:0], 1'b1};
         end else begin
            rem_in = acc[33:0];
            root_in = {prev_root[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k] <= rad_in;
            rem_ff[k] <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_root = root_ff[STAGES-1];
   assign out_side = side_ff[STAGES-1];

`ifndef SYNTHESIS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] |-> rem_ff[STAGES-1] <= {1'b0, root_ff[STAGES-1], 1'b0})
      else $error("square root remainder above twice the root");
`endif

endmodule

// ===== rtl/scc_div.sv =====
// three lane pipelined restoring divider for the normal components
module scc_div #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W = 1
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [31:0] in_num [3],
   input  logic [31:0] in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic out_valid,
   output logic [FRAC_BITS:0] out_quot [3],
   output logic [SIDE_W-1:0] out_side
);

   localparam int STEPS = FRAC_BITS + 1;
   localparam int QW = FRAC_BITS + 1;
   localparam logic [QW-1:0] QUOT_MAX = {1'b1, {FRAC_BITS{1'b0}}};

   logic valid_ff [STEPS];
   logic [31:0] den_ff [STEPS];
   logic [31:0] rem_ff [STEPS][3];
   logic [QW-1:0] quot_ff [STEPS][3];
   logic [SIDE_W-1:0] side_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic prev_valid;
      logic [31:0] prev_den;
      logic [31:0] prev_rem [3];
      logic [QW-1:0] prev_quot [3];
      logic [SIDE_W-1:0] prev_side;
      logic next_bit [3];
      logic [32:0] acc [3];
      logic [31:0] rem_in [3];
      logic [QW-1:0] quot_in [3];

      // numerator is num shifted up by the fraction bits, top bits preloaded
      if (k == 0) begin : g_head
         always_comb begin
            prev_valid = in_valid;
            prev_den = in_den;
            prev_side = in_side;
            for (int i = 0; i < 3; i++) begin
               prev_rem[i] = {1'b0, in_num[i][31:1]};
               prev_quot[i] = '0;
               next_bit[i] = in_num[i][0];
            end
         end
      end else begin : g_tail
         always_comb begin
            prev_valid = valid_ff[k-1];
            prev_den = den_ff[k-1];
            prev_side = side_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               prev_rem[i] = rem_ff[k-1][i];
               prev_quot[i] = quot_ff[k-1][i];
               next_bit[i] = 1'b0;
            end
         end
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            acc[i] = {prev_rem[i], next_bit[i]};
            if (acc[i] >= {1'b0, prev_den}) begin
               rem_in[i] = 32'(acc[i] - {1'b0, prev_den});
               quot_in[i] = {prev_quot[i][QW-2:0], 1'b1};
            end else begin
               rem_in[i] = acc[i][31:0];
               quot_in[i] = {prev_quot[i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k] <= prev_den;
            side_ff[k] <= prev_side;
            for (int i = 0; i < 3; i++) begin
               rem_ff[k][i] <= rem_in[i];
               quot_ff[k][i] <= quot_in[i];
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_side = side_ff[STEPS-1];
   always_comb begin
      for (int i = 0; i < 3; i++) out_quot[i] = quot_ff[STEPS-1][i];
   end

`ifndef SYNTHESIS
   a_unit_quot: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STEPS-1] && den_ff[STEPS-1] != 32'd0 |->
         quot_ff[STEPS-1][0] <= QUOT_MAX && quot_ff[STEPS-1][1] <= QUOT_MAX &&
         quot_ff[STEPS-1][2] <= QUOT_MAX)
      else $error("normal component above one");
`endif

endmodule

// ===== rtl/sphere_capsule_contact_core.sv =====
// top level of the sphere capsule contact core
// Tests one sphere per word against the capsule held in the csr registers and returns
// touching, unit normal in Q1.FRAC_BITS, contact point in Q(31-FRAC_BITS).FRAC_BITS and
// surface part. A new word is taken every clock while no result waits unaccepted; the path
// runs through the five stage projection pipeline, three length stages, the 32 stage square
// root, the FRAC_BITS + 1 stage normal divider and two output stages. The whole pipeline
// holds while a result waits, so req_ready is low only while a result waits and rsp_ready
// is low. Csr writes are taken at any time and belong only where no word is in flight.
module sphere_capsule_contact_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [scc_pkg::COORD_W-1:0] req_sphere_center_x,
   input  logic signed [scc_pkg::COORD_W-1:0] req_sphere_center_y,
   input  logic signed [scc_pkg::COORD_W-1:0] req_sphere_center_z,
   input  logic [scc_pkg::LEN_W-1:0] req_sphere_radius,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_touching,
   output logic signed [scc_pkg::AXIS_W-1:0] rsp_normal_x,
   output logic signed [scc_pkg::AXIS_W-1:0] rsp_normal_y,
   output logic signed [scc_pkg::AXIS_W-1:0] rsp_normal_z,
   output logic signed [scc_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [scc_pkg::COORD_W-1:0] rsp_point_y,
   output logic signed [scc_pkg::COORD_W-1:0] rsp_point_z,
   output logic [1:0] rsp_surface_part,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [scc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [scc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = scc_pkg::COORD_W;
   localparam int AW = scc_pkg::AXIS_W;
   localparam int LW = scc_pkg::LEN_W;
   localparam int VW = scc_pkg::vec_width(FRAC_BITS);
   localparam int QW = FRAC_BITS + 1;
   localparam int NW = FRAC_BITS + 2;
   localparam int MPW = NW + CW;
   localparam int PAW = MPW - FRAC_BITS;
   localparam int OPW = (VW > PAW ? VW : PAW) + 1;
   localparam int WN = NW > AW ? NW : AW;

   typedef struct packed {
      logic hit;
      logic [2:0] neg;
      logic [2:0][31:0] mag;
      logic [2:0][VW-1:0] base;
      scc_pkg::part_type part;
   } root_side_type;

   typedef struct packed {
      logic hit;
      logic len_zero;
      logic [2:0] neg;
      logic [2:0][VW-1:0] base;
      scc_pkg::part_type part;
   } div_side_type;

   scc_pkg::capsule_type capsule_ff;
   logic en;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capsule_ff.center <= '0;
         capsule_ff.axis[0] <= '0;
         capsule_ff.axis[1] <= '0;
         capsule_ff.axis[2] <= scc_pkg::AXIS_Z_RESET;
         capsule_ff.half_height <= scc_pkg::HALF_HEIGHT_RESET;
         capsule_ff.radius <= scc_pkg::RADIUS_RESET;
      end else if (csr_valid) begin
         case (scc_pkg::csr_index_type'(csr_index))
            scc_pkg::REG_CENTER_X: capsule_ff.center[0] <= csr_wdata;
            scc_pkg::REG_CENTER_Y: capsule_ff.center[1] <= csr_wdata;
            scc_pkg::REG_CENTER_Z: capsule_ff.center[2] <= csr_wdata;
            scc_pkg::REG_AXIS_X: capsule_ff.axis[0] <= csr_wdata[AW-1:0];
            scc_pkg::REG_AXIS_Y: capsule_ff.axis[1] <= csr_wdata[AW-1:0];
            scc_pkg::REG_AXIS_Z: capsule_ff.axis[2] <= csr_wdata[AW-1:0];
            scc_pkg::REG_HALF_HEIGHT: capsule_ff.half_height <= csr_wdata[LW-1:0];
            scc_pkg::REG_RADIUS: capsule_ff.radius <= csr_wdata[LW-1:0];
            default: capsule_ff <= capsule_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // projection
   logic signed [CW-1:0] req_center [3];
   logic g_valid;
   logic [LW-1:0] g_radius;
   scc_pkg::part_type g_part;
   logic signed [VW-1:0] g_base [3];
   logic signed [VW-1:0] g_offset [3];

   assign req_center[0] = req_sphere_center_x;
   assign req_center[1] = req_sphere_center_y;
   assign req_center[2] = req_sphere_center_z;

   scc_geom #(
      .FRAC_BITS(FRAC_BITS),
      .VEC_W(VW)
   ) u_geom (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(req_valid),
      .sphere_center(req_center),
      .sphere_radius(req_sphere_radius),
      .capsule(capsule_ff),
      .out_valid(g_valid),
      .out_radius(g_radius),
      .out_part(g_part),
      .out_base(g_base),
      .out_offset(g_offset)
   );

   // offset magnitude, squares, radius test
   logic t1_valid_ff, t2_valid_ff, t3_valid_ff;
   logic [31:0] t1_mag_in [3];
   logic [31:0] t1_mag_ff [3];
   logic [2:0] t1_neg_in, t1_neg_ff;
   logic t1_far_in, t1_far_ff;
   logic [LW-1:0] t1_sr_ff;
   logic [2:0][VW-1:0] t1_base_ff;
   scc_pkg::part_type t1_part_ff;

   always_comb begin
      logic [VW-1:0] vabs;
      t1_far_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         t1_neg_in[i] = g_offset[i][VW-1];
         vabs = t1_neg_in[i] ? VW'(-g_offset[i]) : VW'(g_offset[i]);
         t1_mag_in[i] = vabs[31:0];
         if (|vabs[VW-1:32]) t1_far_in = 1'b1;
      end
   end

   logic [63:0] t2_sq_in [3];
   logic [63:0] t2_sq_ff [3];
   logic [31:0] t2_rsum;
   logic [63:0] t2_rsq_in, t2_rsq_ff;
   logic [31:0] t2_mag_ff [3];
   logic [2:0] t2_neg_ff;
   logic t2_far_ff;
   logic [2:0][VW-1:0] t2_base_ff;
   scc_pkg::part_type t2_part_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) t2_sq_in[i] = 64'(t1_mag_ff[i]) * 64'(t1_mag_ff[i]);
      t2_rsum = {1'b0, capsule_ff.radius} + {1'b0, t1_sr_ff};
      t2_rsq_in = 64'(t2_rsum) * 64'(t2_rsum);
   end

   logic [65:0] t3_tot;
   logic t3_hit_in, t3_hit_ff;
   logic [63:0] t3_len2_ff;
   logic [31:0] t3_mag_ff [3];
   logic [2:0] t3_neg_ff;
   logic [2:0][VW-1:0] t3_base_ff;
   scc_pkg::part_type t3_part_ff;

   assign t3_tot = 66'(t2_sq_ff[0]) + 66'(t2_sq_ff[1]) + 66'(t2_sq_ff[2]);
   assign t3_hit_in = !t2_far_ff && (t3_tot <= 66'(t2_rsq_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
      end else if (en) begin
         t1_valid_ff <= g_valid;
         t2_valid_ff <= t1_valid_ff;
         t3_valid_ff <= t2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_neg_ff <= t1_neg_in;
         t1_far_ff <= t1_far_in;
         t1_sr_ff <= g_radius;
         t1_part_ff <= g_part;
         t2_rsq_ff <= t2_rsq_in;
         t2_neg_ff <= t1_neg_ff;
         t2_far_ff <= t1_far_ff;
         t2_base_ff <= t1_base_ff;
         t2_part_ff <= t1_part_ff;
         t3_hit_ff <= t3_hit_in;
         t3_len2_ff <= t3_tot[63:0];
         t3_neg_ff <= t2_neg_ff;
         t3_base_ff <= t2_base_ff;
         t3_part_ff <= t2_part_ff;
         for (int i = 0; i < 3; i++) begin
            t1_mag_ff[i] <= t1_mag_in[i];
            t1_base_ff[i] <= g_base[i];
            t2_sq_ff[i] <= t2_sq_in[i];
            t2_mag_ff[i] <= t1_mag_ff[i];
            // a miss divides zero, which keeps the quotient in range
            t3_mag_ff[i] <= t3_hit_in ? t2_mag_ff[i] : 32'd0;
         end
      end
   end

   // length
   root_side_type r_side_in, r_side;
   logic [$bits(root_side_type)-1:0] r_side_out;
   logic r_valid;
   logic [31:0] r_root;

   always_comb begin
      r_side_in.hit = t3_hit_ff;
      r_side_in.neg = t3_neg_ff;
      for (int i = 0; i < 3; i++) r_side_in.mag[i] = t3_mag_ff[i];
      r_side_in.base = t3_base_ff;
      r_side_in.part = t3_part_ff;
   end

   scc_isqrt #(
      .SIDE_W($bits(root_side_type))
   ) u_isqrt (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(t3_valid_ff),
      .in_radicand(t3_len2_ff),
      .in_side(r_side_in),
      .out_valid(r_valid),
      .out_root(r_root),
      .out_side(r_side_out)
   );

   assign r_side = root_side_type'(r_side_out);

   // normal
   div_side_type d_side_in, d_side;
   logic [$bits(div_side_type)-1:0] d_side_out;
   logic [31:0] d_num [3];
   logic d_valid;
   logic [QW-1:0] d_quot [3];

   always_comb begin
      d_side_in.hit = r_side.hit;
      d_side_in.len_zero = r_root == 32'd0;
      d_side_in.neg = r_side.neg;
      d_side_in.base = r_side.base;
      d_side_in.part = r_side.part;
      for (int i = 0; i < 3; i++) d_num[i] = r_side.mag[i];
   end

   scc_div #(
      .FRAC_BITS(FRAC_BITS),
      .SIDE_W($bits(div_side_type))
   ) u_div (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(r_valid),
      .in_num(d_num),
      .in_den(r_root),
      .in_side(d_side_in),
      .out_valid(d_valid),
      .out_quot(d_quot),
      .out_side(d_side_out)
   );

   assign d_side = div_side_type'(d_side_out);

   // signed normal and radius scaling
   logic o1_valid_ff;
   logic o1_hit_ff;
   scc_pkg::part_type o1_part_ff;
   logic [2:0][VW-1:0] o1_base_ff;
   logic signed [NW-1:0] o1_n_in [3];
   logic signed [NW-1:0] o1_n_ff [3];
   logic signed [MPW-1:0] o1_prod_in [3];
   logic signed [MPW-1:0] o1_prod_ff [3];

   always_comb begin
      logic signed [NW-1:0] qx;
      for (int i = 0; i < 3; i++) begin
         qx = NW'(d_quot[i]);
         if (d_side.len_zero) begin
            o1_n_in[i] = '0;
         end else begin
            o1_n_in[i] = d_side.neg[i] ? -qx : qx;
         end
         o1_prod_in[i] = o1_n_in[i] * $signed({1'b0, capsule_ff.radius});
      end
   end

   // output word
   logic rsp_touching_ff;
   logic signed [AW-1:0] rsp_normal_in [3];
   logic signed [AW-1:0] rsp_normal_ff [3];
   logic signed [CW-1:0] rsp_point_in [3];
   logic signed [CW-1:0] rsp_point_ff [3];
   scc_pkg::part_type rsp_part_ff;

   always_comb begin
      logic signed [WN-1:0] nw;
      logic signed [OPW-1:0] pw;
      for (int i = 0; i < 3; i++) begin
         nw = WN'(o1_n_ff[i]);
         if (nw[WN-1:AW-1] != {(WN-AW+1){nw[WN-1]}}) begin
            rsp_normal_in[i] = nw[WN-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
         end else begin
            rsp_normal_in[i] = nw[AW-1:0];
         end
         pw = OPW'($signed(o1_base_ff[i])) + OPW'($signed(o1_prod_ff[i][MPW-1:FRAC_BITS]));
         if (pw[OPW-1:CW-1] != {(OPW-CW+1){pw[OPW-1]}}) begin
            rsp_point_in[i] = pw[OPW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end else begin
            rsp_point_in[i] = pw[CW-1:0];
         end
         if (!o1_hit_ff) begin
            rsp_normal_in[i] = '0;
            rsp_point_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         o1_valid_ff <= d_valid;
         rsp_valid_ff <= o1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o1_hit_ff <= d_side.hit;
         o1_part_ff <= d_side.part;
         o1_base_ff <= d_side.base;
         rsp_touching_ff <= o1_hit_ff;
         rsp_part_ff <= o1_hit_ff ? o1_part_ff : scc_pkg::PART_SIDE;
         for (int i = 0; i < 3; i++) begin
            o1_n_ff[i] <= o1_n_in[i];
            o1_prod_ff[i] <= o1_prod_in[i];
            rsp_normal_ff[i] <= rsp_normal_in[i];
            rsp_point_ff[i] <= rsp_point_in[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_touching = rsp_touching_ff;
   assign rsp_normal_x = rsp_normal_ff[0];
   assign rsp_normal_y = rsp_normal_ff[1];
   assign rsp_normal_z = rsp_normal_ff[2];
   assign rsp_point_x = rsp_point_ff[0];
   assign rsp_point_y = rsp_point_ff[1];
   assign rsp_point_z = rsp_point_ff[2];
   assign rsp_surface_part = rsp_part_ff;

`ifndef SYNTHESIS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_touching |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0 &&
         rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0 &&
         rsp_surface_part == scc_pkg::PART_SIDE)
      else $error("miss word carries nonzero fields");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_touching) && $stable(rsp_surface_part) &&
         $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_point_z))
      else $error("result word changed while waiting");
`endif

endmodule

// ===== tb/tb_top.sv =====
// testbench for the sphere capsule contact core: directed table, random spheres, predictor check
`timescale 1ns / 1ps
module tb_top;

   localparam int FRAC = 16;
   localparam int AW = scc_pkg::AXIS_W;
   localparam int CW = scc_pkg::COORD_W;
   localparam int LW = scc_pkg::LEN_W;
   localparam int DRAIN = 43 + FRAC + 20;
   localparam longint LIMIT = 800000;

   typedef struct {
      bit touching;
      logic signed [AW-1:0] nx, ny, nz;
      logic signed [CW-1:0] px, py, pz;
      scc_pkg::part_type part;
   } contact_type;

   typedef struct {
      logic [CW-1:0] x, y, z;
      logic [LW-1:0] r;
      bit typed;
      contact_type res;
   } sphere_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [CW-1:0] req_sphere_center_x = 0, req_sphere_center_y = 0;
   logic signed [CW-1:0] req_sphere_center_z = 0;
   logic [LW-1:0] req_sphere_radius = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_touching;
   logic signed [AW-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic signed [CW-1:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic [1:0] rsp_surface_part;
   logic csr_valid = 0;
   logic csr_ready;
   logic [scc_pkg::CSR_INDEX_W-1:0] csr_index = 0;
   logic [scc_pkg::CSR_DATA_W-1:0] csr_wdata = 0;

   logic [31:0] capsule_reg [8];
   contact_type contact_q [$];
   sphere_row_type dir_rows [$];
   int errors = 0;
   int words_sent = 0;
   int words_back = 0;
   int hits_seen = 0;
   int caps_seen = 0;
   longint cycles = 0;

   sphere_capsule_contact_core #(.FRAC_BITS(FRAC)) dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint sat_to(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic contact_type predict_contact(logic [31:0] sx, logic [31:0] sy,
                                                   logic [31:0] sz, logic [30:0] sr);
      longint cc[3], ax[3], sc[3], d[3], v[3], base[3], nn[3];
      longint h, a, p;
      longint unsigned hh, rad, rsum, m, sq, lo, len, vv, rt, b;
      int carry;
      bit hit;
      contact_type res;
      sc[0] = longint'($signed(sx));
      sc[1] = longint'($signed(sy));
      sc[2] = longint'($signed(sz));
      hh = capsule_reg[6][30:0];
      rad = capsule_reg[7][30:0];
      rsum = rad + sr;
      h = 0;
      for (int i = 0; i < 3; i++) begin
         cc[i] = longint'($signed(capsule_reg[i]));
         ax[i] = longint'($signed(capsule_reg[3 + i][17:0]));
         d[i] = sc[i] - cc[i];
         h += ax[i] * d[i];
      end
      h = h >>> FRAC;
      if (mag(h) < hh) begin
         res.part = scc_pkg::PART_SIDE;
         for (int i = 0; i < 3; i++) begin
            a = (ax[i] * h) >>> FRAC;
            base[i] = cc[i] + a;
            v[i] = d[i] - a;
         end
      end else begin
         res.part = h >= 0 ? scc_pkg::PART_TOP : scc_pkg::PART_BOTTOM;
         for (int i = 0; i < 3; i++) begin
            a = (ax[i] * longint'(hh)) >>> FRAC;
            base[i] = h >= 0 ? cc[i] + a : cc[i] - a;
            v[i] = sc[i] - base[i];
         end
      end
      hit = 1;
      lo = 0;
      carry = 0;
      for (int i = 0; i < 3; i++) begin
         m = mag(v[i]);
         if (m >= (64'd1 << 32)) hit = 0;
         sq = m * m;
         lo += sq;
         if (lo < sq) carry++;
      end
      if (hit && (carry != 0 || lo > rsum * rsum)) hit = 0;
      if (!hit) begin
         res.touching = 0;
         res.nx = '0;
         res.ny = '0;
         res.nz = '0;
         res.px = '0;
         res.py = '0;
         res.pz = '0;
         res.part = scc_pkg::PART_SIDE;
         return res;
      end
      // integer square root of the squared offset length
      vv = lo;
      rt = 0;
      b = 64'd1 << 62;
      while (b > vv) b >>= 2;
      while (b != 0) begin
         if (vv >= rt + b) begin
            vv -= rt + b;
            rt = (rt >> 1) + b;
         end else begin
            rt >>= 1;
         end
         b >>= 2;
      end
      len = rt;
      for (int i = 0; i < 3; i++) begin
         if (len == 0) nn[i] = 0;
         else begin
            m = (mag(v[i]) << FRAC) / len;
            nn[i] = v[i] < 0 ? -longint'(m) : longint'(m);
         end
      end
      res.touching = 1;
      res.nx = AW'(sat_to(nn[0], AW));
      res.ny = AW'(sat_to(nn[1], AW));
      res.nz = AW'(sat_to(nn[2], AW));
      p = base[0] + ((nn[0] * longint'(rad)) >>> FRAC);
      res.px = CW'(sat_to(p, CW));
      p = base[1] + ((nn[1] * longint'(rad)) >>> FRAC);
      res.py = CW'(sat_to(p, CW));
      p = base[2] + ((nn[2] * longint'(rad)) >>> FRAC);
      res.pz = CW'(sat_to(p, CW));
      return res;
   endfunction

   function automatic contact_type mk(bit t, longint nx, longint ny, longint nz, longint px,
                                      longint py, longint pz, scc_pkg::part_type part);
      contact_type c;
      c.touching = t;
      c.nx = AW'(nx);
      c.ny = AW'(ny);
      c.nz = AW'(nz);
      c.px = CW'(px);
      c.py = CW'(py);
      c.pz = CW'(pz);
      c.part = part;
      return c;
   endfunction

   function automatic void check_field(string name, longint e, longint a);
      if (e != a) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      end
   endfunction

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 65) return 0;
      if (k < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result monitor and cycle limit
   always @(posedge clock) begin
      contact_type e;
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         words_back++;
         if (contact_q.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing expected", $time);
         end else begin
            e = contact_q.pop_front();
            if (e.touching) hits_seen++;
            if (e.touching && e.part != scc_pkg::PART_SIDE) caps_seen++;
            check_field("touching", e.touching, rsp_touching);
            check_field("normal_x", e.nx, rsp_normal_x);
            check_field("normal_y", e.ny, rsp_normal_y);
            check_field("normal_z", e.nz, rsp_normal_z);
            check_field("point_x", e.px, rsp_point_x);
            check_field("point_y", e.py, rsp_point_y);
            check_field("point_z", e.pz, rsp_point_z);
            check_field("surface_part", e.part, rsp_surface_part);
         end
      end
   end

   // receiver: random stalls plus one long hold to back up the pipeline
   initial begin
      int stall_left;
      int hold_left;
      bit held_once;
      stall_left = 0;
      hold_left = 0;
      held_once = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 0;
         end else if (!held_once && words_sent >= 300) begin
            held_once = 1;
            hold_left = 400;
            rsp_ready = 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 0;
         end else begin
            stall_left = pick_gap();
            rsp_ready = stall_left == 0;
            if (stall_left > 0) stall_left--;
         end
      end
   end

   task automatic write_reg(scc_pkg::csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      capsule_reg[idx] = data;
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (contact_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic load_capsule(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               longint axx, longint axy, longint axz,
                               logic [30:0] hh, logic [30:0] rad);
      drain();
      write_reg(scc_pkg::REG_CENTER_X, cx);
      write_reg(scc_pkg::REG_CENTER_Y, cy);
      write_reg(scc_pkg::REG_CENTER_Z, cz);
      write_reg(scc_pkg::REG_AXIS_X, 32'(axx));
      write_reg(scc_pkg::REG_AXIS_Y, 32'(axy));
      write_reg(scc_pkg::REG_AXIS_Z, 32'(axz));
      write_reg(scc_pkg::REG_HALF_HEIGHT, {1'b0, hh});
      write_reg(scc_pkg::REG_RADIUS, {1'b0, rad});
   endtask

   task automatic send_sphere(sphere_row_type row);
      int gap;
      @(negedge clock);
      req_valid = 1;
      req_sphere_center_x = row.x;
      req_sphere_center_y = row.y;
      req_sphere_center_z = row.z;
      req_sphere_radius = row.r;
      do @(posedge clock); while (!req_ready);
      contact_q.push_back(row.typed ? row.res : predict_contact(row.x, row.y, row.z, row.r));
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic add_row(longint x, longint y, longint z, longint r, bit typed,
                          contact_type res);
      sphere_row_type row;
      row.x = 32'(x);
      row.y = 32'(y);
      row.z = 32'(z);
      row.r = 31'(r);
      row.typed = typed;
      row.res = res;
      dir_rows.push_back(row);
   endtask

   task automatic random_phase(int count);
      sphere_row_type row;
      longint span, cc;
      for (int n = 0; n < count; n++) begin
         row.typed = 0;
         if ($urandom_range(0, 99) < 20) begin
            row.x = $urandom();
            row.y = $urandom();
            row.z = $urandom();
            row.r = 31'($urandom());
         end else begin
            span = 2 * (longint'(capsule_reg[6][30:0]) + longint'(capsule_reg[7][30:0])) + 65536;
            if (span > (longint'(1) << 30)) span = longint'(1) << 30;
            cc = longint'($signed(capsule_reg[0]));
            row.x = 32'(cc + longint'($urandom_range(0, 32'(2 * span))) - span);
            cc = longint'($signed(capsule_reg[1]));
            row.y = 32'(cc + longint'($urandom_range(0, 32'(2 * span))) - span);
            cc = longint'($signed(capsule_reg[2]));
            row.z = 32'(cc + longint'($urandom_range(0, 32'(2 * span))) - span);
            row.r = 31'($urandom_range(0, 32'(span / 2)));
         end
         send_sphere(row);
      end
   endtask

   initial begin
      contact_type none;
      none = mk(0, 0, 0, 0, 0, 0, 0, scc_pkg::PART_SIDE);
      foreach (capsule_reg[i]) capsule_reg[i] = 0;
      capsule_reg[5] = 32'(scc_pkg::AXIS_Z_RESET);
      capsule_reg[6] = 32'(scc_pkg::HALF_HEIGHT_RESET);
      capsule_reg[7] = 32'(scc_pkg::RADIUS_RESET);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset capsule: unit capsule along z at the origin
      add_row(3 * 65536, 0, 0, 0, 1, none);
      add_row(98304, 0, 0, 65536, 1, mk(1, 65536, 0, 0, 65536, 0, 0, scc_pkg::PART_SIDE));
      add_row(0, 0, 0, 0, 1, mk(1, 0, 0, 0, 0, 0, 0, scc_pkg::PART_SIDE));
      add_row(0, 0, 3 * 65536, 65536, 1, mk(1, 0, 0, 65536, 0, 0, 131072, scc_pkg::PART_TOP));
      add_row(0, 0, -3 * 65536, 65536, 1,
              mk(1, 0, 0, -65536, 0, 0, -131072, scc_pkg::PART_BOTTOM));
      add_row(0, 0, 65536, 0, 1, mk(1, 0, 0, 0, 0, 0, 65536, scc_pkg::PART_TOP));
      add_row(0, 65536 + 32768, -65536, 32768, 0, none);
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, none);
      add_row(-(longint'(1) << 31), -(longint'(1) << 31), -(longint'(1) << 31), 0, 0, none);
      add_row(32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF, 0, none);
      foreach (dir_rows[i]) send_sphere(dir_rows[i]);

      // extreme capsule: far components and saturated points
      load_capsule(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -65536, 0, 0,
                   31'h7FFF_FFFF, 31'h7FFF_FFFF);
      dir_rows.delete();
      add_row(-(longint'(1) << 31), -(longint'(1) << 31), -(longint'(1) << 31), 0, 0, none);
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, none);
      add_row(0, 0, 0, 31'h7FFF_FFFF, 0, none);
      add_row(32'h7FFF_FFFF, 32'h7FFF_0000, 32'h7FFF_FFFF, 0, 0, none);
      foreach (dir_rows[i]) send_sphere(dir_rows[i]);

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: load_capsule(0, 0, 0, 0, 0, 65536, 65536, 65536);
            1: load_capsule(32'h7FFF_FFF0, 32'h7FFF_FFF0, 0, 65536, 0, 0,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF);
            2: load_capsule(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -65536, 0, 0, 0, 0);
            3: load_capsule($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24),
                            32'(-longint'($urandom_range(0, 1 << 24))), 46341, 46341, 0,
                            31'($urandom_range(0, 1 << 20)),
                            31'($urandom_range(0, 1 << 20)));
            4: load_capsule($urandom(), $urandom(), $urandom(),
                            longint'($urandom_range(0, 131072)) - 65536,
                            longint'($urandom_range(0, 131072)) - 65536,
                            longint'($urandom_range(0, 131072)) - 65536,
                            31'($urandom_range(0, 1 << 22)),
                            31'($urandom_range(0, 1 << 22)));
            5: load_capsule($urandom_range(0, 1 << 26), 0, $urandom_range(0, 1 << 26),
                            0, -65536, 0, 1 << 24, 1 << 20);
            default: load_capsule(0, 0, 0, 0, 0, 0, 31'($urandom_range(0, 1 << 18)),
                                  31'($urandom_range(1, 1 << 18)));
         endcase
         random_phase(148);
      end

      @(negedge clock);
      req_valid = 0;
      drain();
      if (contact_q.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, contact_q.size());
      end
      $display("covered %0d sphere words over 9 capsule settings, %0d results back",
               words_sent, words_back);
      $display("%0d contacts, %0d of them on a cap, %0d mismatches", hits_seen, caps_seen,
               errors);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/scc_pkg.sv
rtl/scc_geom.sv
rtl/scc_isqrt.sv
rtl/scc_div.sv
rtl/sphere_capsule_contact_core.sv
tb/tb_top.sv
